// ===== rtl/core/nec_ir_frame_transmitter_core_defines.svh =====
// Assertion macros shared by the NEC infrared transmitter RTL.
`ifndef NEC_IR_FRAME_TRANSMITTER_CORE_DEFINES_SVH
`define NEC_IR_FRAME_TRANSMITTER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication check.
`define NECIRTX_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("necirtx: same-cycle check failed");
// Next-cycle implication check.
`define NECIRTX_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("necirtx: next-cycle check failed");
`else
`define NECIRTX_ASSERT_IMPL(name, clk, rst, ante, cons)
`define NECIRTX_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/necirtx_pkg.sv =====
// Types, constants and helpers shared by the NEC infrared transmitter.
package necirtx_pkg;

  // Width of every length register, in carrier half-period ticks.
  localparam int TICK_W = 12;
  localparam int CFG_INDEX_W = 3;

  typedef logic [TICK_W-1:0] tick_t;
  typedef logic [7:0] byte_t;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LEADER_MARK  = 3'd0,
    REG_LEADER_SPACE = 3'd1,
    REG_BIT_MARK     = 3'd2,
    REG_ONE_SPACE    = 3'd3,
    REG_ZERO_SPACE   = 3'd4,
    REG_STOP_SPACE   = 3'd5
  } cfg_reg_e;

  // Register values after reset.
  localparam tick_t LEADER_MARK_RESET  = 12'd692;
  localparam tick_t LEADER_SPACE_RESET = 12'd346;
  localparam tick_t BIT_MARK_RESET     = 12'd43;
  localparam tick_t ONE_SPACE_RESET    = 12'd130;
  localparam tick_t ZERO_SPACE_RESET   = 12'd43;
  localparam tick_t STOP_SPACE_RESET   = 12'd43;

  // Input function codes.
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_START = 1'b1;

  // One result item.
  typedef struct packed {
    logic emitter_level;
    logic busy_res;
    logic frame_done;
  } result_t;

  // The 32-bit NEC word: address, inverted address, command, inverted command.
  function automatic logic [31:0] nec_word(input byte_t address, input byte_t command);
    nec_word = {~command, command, ~address, address};
  endfunction

endpackage

// ===== rtl/core/necirtx_in_if.sv =====
// Input channel: tick or start items with address and command.
interface necirtx_in_if;
  import necirtx_pkg::*;

  logic  valid;
  logic  ready;
  logic  func;
  byte_t address;
  byte_t command;

  modport source (output valid, output func, output address, output command, input ready);
  modport sink (input valid, input func, input address, input command, output ready);
endinterface

// ===== rtl/core/necirtx_out_if.sv =====
// Output channel: one result item per accepted input item.
interface necirtx_out_if;
  logic valid;
  logic ready;
  logic emitter_level;
  logic busy_res;
  logic frame_done;

  modport source (output valid, output emitter_level, output busy_res, output frame_done,
                  input ready);
  modport sink (input valid, input emitter_level, input busy_res, input frame_done,
                output ready);
endinterface

// ===== rtl/core/necirtx_cfg_if.sv =====
// Configuration write channel: register index and write data.
interface necirtx_cfg_if;
  import necirtx_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  tick_t                  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/nec_ir_frame_transmitter_core.sv =====
// NEC infrared frame transmitter: phase sequencer, tick counter and result buffer.
// Results leave in order; a result is offered on the cycle after its item if none waits.
// Throughput: one item per cycle while the buffer is not full; the update is one pass of logic.
// A two-entry result buffer lets items keep flowing while a result waits to be taken.
// Reset (synchronous, active high) idles the sequencer, turns the emitter off,
// empties the result buffer and loads the default phase lengths.
`include "nec_ir_frame_transmitter_core_defines.svh"

module nec_ir_frame_transmitter_core #(
  parameter int FRAME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  necirtx_in_if.sink  in_ch,
  necirtx_out_if.source out_ch,
  necirtx_cfg_if.sink cfg_ch
);
  import necirtx_pkg::*;

  // Phase numbering: 0 idle, 1 leader mark, 2 leader space, odd data marks,
  // even data spaces, then the final mark and the stop space.
  localparam int PHASE_W = $clog2(2 * FRAME_BITS + 5);
  localparam logic [PHASE_W-1:0] PH_IDLE         = PHASE_W'(0);
  localparam logic [PHASE_W-1:0] PH_LEADER_MARK  = PHASE_W'(1);
  localparam logic [PHASE_W-1:0] PH_LEADER_SPACE = PHASE_W'(2);
  localparam logic [PHASE_W-1:0] PH_FIRST_SPACE  = PHASE_W'(4);
  localparam logic [PHASE_W-1:0] PH_FINAL_MARK   = PHASE_W'(2 * FRAME_BITS + 3);
  localparam logic [PHASE_W-1:0] PH_STOP_SPACE   = PHASE_W'(2 * FRAME_BITS + 4);

  // Length registers.
  tick_t leader_mark_ticks;
  tick_t leader_space_ticks;
  tick_t bit_mark_ticks;
  tick_t one_space_ticks;
  tick_t zero_space_ticks;
  tick_t stop_space_ticks;

  // Sequencer state.
  logic [PHASE_W-1:0]    phase_index, phase_index_next;
  tick_t                 tick_count, tick_count_next;
  logic [FRAME_BITS-1:0] frame_bits, frame_bits_next;
  logic                  out_level, out_level_next;
  logic                  sending, sending_next;
  logic                  done;

  // Per-phase decode.
  tick_t                 tick_inc;
  tick_t                 phase_len;
  logic                  phase_mark;
  logic                  data_space;
  logic                  phase_end;
  logic [63:0]           word_ext;

  // Result buffer.
  result_t               res;
  result_t               res_buf [2];
  logic                  wr_ptr;
  logic                  rd_ptr;
  logic [1:0]            count, count_next;
  logic                  push;
  logic                  pop;

  // Terms used by the checks at the end.
  logic                  start_idle;
  logic                  leader_fresh;

  // Configuration writes are always taken; unknown indexes are dropped.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      leader_mark_ticks  <= LEADER_MARK_RESET;
      leader_space_ticks <= LEADER_SPACE_RESET;
      bit_mark_ticks     <= BIT_MARK_RESET;
      one_space_ticks    <= ONE_SPACE_RESET;
      zero_space_ticks   <= ZERO_SPACE_RESET;
      stop_space_ticks   <= STOP_SPACE_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_e'(cfg_ch.index))
        REG_LEADER_MARK:  leader_mark_ticks  <= cfg_ch.data;
        REG_LEADER_SPACE: leader_space_ticks <= cfg_ch.data;
        REG_BIT_MARK:     bit_mark_ticks     <= cfg_ch.data;
        REG_ONE_SPACE:    one_space_ticks    <= cfg_ch.data;
        REG_ZERO_SPACE:   zero_space_ticks   <= cfg_ch.data;
        REG_STOP_SPACE:   stop_space_ticks   <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  // Decode the current phase: marks are the odd phases up to the final mark.
  assign phase_mark = phase_index[0] && (phase_index <= PH_FINAL_MARK);
  assign data_space = !phase_index[0] && (phase_index >= PH_FIRST_SPACE) &&
                      (phase_index < PH_STOP_SPACE);
  assign tick_inc   = tick_count + tick_t'(1);

  // Length of the phase in progress. A zero length ends after one tick
  // because the incremented count is never below one.
  always_comb begin
    if (phase_index == PH_LEADER_MARK) begin
      phase_len = leader_mark_ticks;
    end else if (phase_index == PH_LEADER_SPACE) begin
      phase_len = leader_space_ticks;
    end else if (phase_index == PH_STOP_SPACE) begin
      phase_len = stop_space_ticks;
    end else if (phase_mark) begin
      phase_len = bit_mark_ticks;
    end else if (frame_bits[0]) begin
      phase_len = one_space_ticks;
    end else begin
      phase_len = zero_space_ticks;
    end
  end

  assign phase_end = (tick_inc >= phase_len);
  assign word_ext  = {32'd0, nec_word(in_ch.address, in_ch.command)};

  // Next state for one item.
  always_comb begin
    phase_index_next = phase_index;
    tick_count_next  = tick_count;
    frame_bits_next  = frame_bits;
    out_level_next   = out_level;
    sending_next     = sending;
    done             = 1'b0;
    if (in_ch.func == FUNC_START) begin
      if (!sending) begin
        frame_bits_next  = word_ext[FRAME_BITS-1:0];
        phase_index_next = PH_LEADER_MARK;
        tick_count_next  = '0;
        out_level_next   = 1'b0;
        sending_next     = 1'b1;
      end
    end else if (sending) begin
      tick_count_next = tick_inc;
      out_level_next  = phase_mark ? !out_level : 1'b0;
      if (phase_end) begin
        tick_count_next = '0;
        if (data_space) begin
          frame_bits_next = frame_bits >> 1;
        end
        if (phase_index >= PH_STOP_SPACE) begin
          phase_index_next = PH_IDLE;
          sending_next     = 1'b0;
          out_level_next   = 1'b0;
          done             = 1'b1;
        end else begin
          phase_index_next = phase_index + PHASE_W'(1);
        end
      end
    end
  end

  assign res = '{emitter_level: out_level_next, busy_res: sending_next, frame_done: done};

  // Handshakes on both sides of the result buffer.
  assign in_ch.ready = (count != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = out_ch.valid && out_ch.ready;
  assign count_next  = count + {1'b0, push} - {1'b0, pop};

  // Sequencer registers advance only on accepted items.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_index <= PH_IDLE;
      tick_count  <= '0;
      frame_bits  <= '0;
      out_level   <= 1'b0;
      sending     <= 1'b0;
    end else if (push) begin
      phase_index <= phase_index_next;
      tick_count  <= tick_count_next;
      frame_bits  <= frame_bits_next;
      out_level   <= out_level_next;
      sending     <= sending_next;
    end
  end

  // Buffer pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count_next;
    end
  end

  // Buffer entries hold payload only.
  always_ff @(posedge clk) begin
    if (push) begin
      res_buf[wr_ptr] <= res;
    end
  end

  assign out_ch.valid         = (count != 2'd0);
  assign out_ch.emitter_level = res_buf[rd_ptr].emitter_level;
  assign out_ch.busy_res      = res_buf[rd_ptr].busy_res;
  assign out_ch.frame_done    = res_buf[rd_ptr].frame_done;

  // A start taken while idle, and the state it must leave behind.
  assign start_idle   = push && !sending && (in_ch.func == FUNC_START);
  assign leader_fresh = sending && (phase_index == PH_LEADER_MARK) && (tick_count == '0);

  // The sequencer rests in the idle phase with the emitter off whenever no frame runs.
  `NECIRTX_ASSERT_IMPL(a_idle_quiet, clk, rst, !sending, (phase_index == PH_IDLE) && !out_level)
  // A start taken while idle opens the leader mark with a fresh count.
  `NECIRTX_ASSERT_NEXT(a_start_leader, clk, rst, start_idle, leader_fresh)
  // The item that ends a frame leaves the sequencer idle.
  `NECIRTX_ASSERT_NEXT(a_done_idle, clk, rst, push && done, !sending && (phase_index == PH_IDLE))

endmodule
